FILE: rtl/core/msd_pkg.sv
// Shared types, widths, request codes and glyph table for the seven-segment driver.
package msd_pkg;

  localparam int REQ_W   = 3;
  localparam int VALUE_W = 8;
  localparam int SEG_W   = 7;
  localparam int DIG_W   = 3;
  localparam int CODE_W  = 5;
  localparam int POS_W   = 2;
  localparam int DIM_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UNITS    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TENS     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_HUNDREDS = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FINISH   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DIM      = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_PERIOD_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_PERIOD_HIGH = 1'b1;

  localparam logic [CODE_W-1:0] CODE_BLANK = 5'd16;
  localparam logic [CODE_W-1:0] CODE_DASH  = 5'd17;
  localparam logic [VALUE_W-1:0] DIGIT_MAX = 8'd9;

  localparam logic [VALUE_W-1:0] DIM_MODE_LOW  = 8'd1;
  localparam logic [VALUE_W-1:0] DIM_MODE_HIGH = 8'd2;
  localparam logic [VALUE_W-1:0] FINISH_ON     = 8'd1;

  localparam logic [DIG_W-1:0] DIG_OFF      = 3'b111;
  localparam logic [DIG_W-1:0] DIG_UNITS    = 3'b110;
  localparam logic [DIG_W-1:0] DIG_TENS     = 3'b101;
  localparam logic [DIG_W-1:0] DIG_HUNDREDS = 3'b011;

  localparam logic [DIM_W-1:0] DIM_PERIOD_LOW_RST  = 4'd3;
  localparam logic [DIM_W-1:0] DIM_PERIOD_HIGH_RST = 4'd6;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [DIG_W-1:0] digit_enable;
    logic             drive_valid;
    logic             accepted;
  } result_t;

  // gfedcba patterns: hex glyphs, then blank, then dash
  function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      5'd0:    seg = 7'h3F;
      5'd1:    seg = 7'h06;
      5'd2:    seg = 7'h5B;
      5'd3:    seg = 7'h4F;
      5'd4:    seg = 7'h66;
      5'd5:    seg = 7'h6D;
      5'd6:    seg = 7'h7D;
      5'd7:    seg = 7'h07;
      5'd8:    seg = 7'h7F;
      5'd9:    seg = 7'h6F;
      5'd10:   seg = 7'h77;
      5'd11:   seg = 7'h7C;
      5'd12:   seg = 7'h39;
      5'd13:   seg = 7'h5E;
      5'd14:   seg = 7'h79;
      5'd15:   seg = 7'h71;
      5'd17:   seg = 7'h40;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/core/msd_in_if.sv
// Input request channel: request type and value.
interface msd_in_if import msd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [VALUE_W-1:0] value;

  modport source(output valid, req_type, value, input ready);
  modport sink(input valid, req_type, value, output ready);
endinterface

FILE: rtl/core/msd_out_if.sv
// Result channel: segment drive, digit enable and status flags.
interface msd_out_if import msd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segments;
  logic [DIG_W-1:0] digit_enable;
  logic             drive_valid;
  logic             accepted;

  modport source(output valid, segments, digit_enable, drive_valid, accepted, input ready);
  modport sink(input valid, segments, digit_enable, drive_valid, accepted, output ready);
endinterface

FILE: rtl/core/msd_cfg_if.sv
// Configuration write channel: register index and data.
interface msd_cfg_if import msd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/mux_seven_segment_driver.sv
// Three-digit multiplexed seven-segment driver, top level.
//
// Channels: in_ch carries requests (refresh tick or a write of units, tens,
// hundreds, finish flag or dim mode); out_ch returns exactly one result per
// request; cfg_ch writes the two dim period registers and is always ready.
// Each request is handled in one pass of logic from the input transfer to the
// result register; a result is valid the cycle after its transfer unless the
// receiver stalls, and one request per cycle is sustained while results are
// taken; the state update (position, digits, dim count) per transfer sets it.
// A skid register behind the result register takes one more result while
// the receiver stalls; in_ch.ready drops only when both are full, and comes
// back the cycle after the receiver takes a result.
// Reset (rst_n low, synchronous) empties both result stages, sets the three
// digits blank, clears position, finish flag, dim mode and dim count, and
// loads the dim periods with 3 and 6.
module mux_seven_segment_driver import msd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  msd_in_if.sink    in_ch,
  msd_out_if.source out_ch,
  msd_cfg_if.sink   cfg_ch
);

  logic [DIM_W-1:0]   dim_period_low_r, dim_period_high_r;
  logic [POS_W-1:0]   position_r, position_nxt;
  logic [CODE_W-1:0]  units_r, units_nxt;
  logic [CODE_W-1:0]  tens_r, tens_nxt;
  logic [CODE_W-1:0]  hundreds_r, hundreds_nxt;
  logic [VALUE_W-1:0] finish_r, finish_nxt;
  logic [VALUE_W-1:0] dim_mode_r, dim_mode_nxt;
  logic [DIM_W-1:0]   dim_count_r, dim_count_nxt;

  result_t res_nxt, out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    in_xfer;

  assign in_ch.ready  = !skid_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_period_low_r  <= DIM_PERIOD_LOW_RST;
      dim_period_high_r <= DIM_PERIOD_HIGH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_DIM_PERIOD_LOW:  dim_period_low_r  <= cfg_ch.data;
        CFG_DIM_PERIOD_HIGH: dim_period_high_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CODE_W-1:0]  code;
    logic [DIG_W-1:0]   enable;
    logic [DIM_W:0]     count_inc;
    logic [DIM_W-1:0]   period;
    logic               lit;
    logic               digit_ok;
    position_nxt  = position_r;
    units_nxt     = units_r;
    tens_nxt      = tens_r;
    hundreds_nxt  = hundreds_r;
    finish_nxt    = finish_r;
    dim_mode_nxt  = dim_mode_r;
    dim_count_nxt = dim_count_r;
    code          = CODE_BLANK;
    enable        = DIG_OFF;
    lit           = 1'b1;
    period        = (dim_mode_r == DIM_MODE_LOW) ? dim_period_low_r : dim_period_high_r;
    count_inc     = {1'b0, dim_count_r} + {{DIM_W{1'b0}}, 1'b1};
    digit_ok      = (in_ch.value <= DIGIT_MAX);
    res_nxt.segments     = '0;
    res_nxt.digit_enable = DIG_OFF;
    res_nxt.drive_valid  = 1'b0;
    res_nxt.accepted     = 1'b0;

    case (in_ch.req_type)
      REQ_TICK: begin
        position_nxt = (position_r == 2'd0 || position_r == 2'd3) ? 2'd1 : position_r + 2'd1;
        case (position_nxt)
          2'd1:    begin code = units_r;    enable = DIG_UNITS;    end
          2'd2:    begin code = tens_r;     enable = DIG_TENS;     end
          default: begin code = hundreds_r; enable = DIG_HUNDREDS; end
        endcase
        if (code != CODE_BLANK) code = {1'b0, code[3:0]};
        if (dim_mode_r == DIM_MODE_LOW || dim_mode_r == DIM_MODE_HIGH) begin
          if (count_inc > {1'b0, period}) begin
            dim_count_nxt = '0;
          end else begin
            dim_count_nxt = count_inc[DIM_W-1:0];
            lit           = 1'b0;
          end
        end else begin
          dim_count_nxt = '0;
        end
        if (!lit) code = CODE_BLANK;
        if (finish_r == FINISH_ON) code = CODE_DASH;
        res_nxt.segments     = glyph(code);
        res_nxt.digit_enable = enable;
        res_nxt.drive_valid  = 1'b1;
      end
      REQ_UNITS: begin
        if (digit_ok) units_nxt = in_ch.value[CODE_W-1:0];
        res_nxt.accepted = digit_ok;
      end
      REQ_TENS: begin
        if (digit_ok) tens_nxt = in_ch.value[CODE_W-1:0];
        res_nxt.accepted = digit_ok;
      end
      REQ_HUNDREDS: begin
        if (digit_ok) hundreds_nxt = in_ch.value[CODE_W-1:0];
        res_nxt.accepted = digit_ok;
      end
      REQ_FINISH: begin
        finish_nxt       = in_ch.value;
        res_nxt.accepted = 1'b1;
      end
      REQ_DIM: begin
        dim_mode_nxt     = in_ch.value;
        res_nxt.accepted = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      units_r     <= CODE_BLANK;
      tens_r      <= CODE_BLANK;
      hundreds_r  <= CODE_BLANK;
      finish_r    <= '0;
      dim_mode_r  <= '0;
      dim_count_r <= '0;
    end else if (in_xfer) begin
      position_r  <= position_nxt;
      units_r     <= units_nxt;
      tens_r      <= tens_nxt;
      hundreds_r  <= hundreds_nxt;
      finish_r    <= finish_nxt;
      dim_mode_r  <= dim_mode_nxt;
      dim_count_r <= dim_count_nxt;
    end
  end

  // result register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_xfer) begin
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ch.ready) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (!out_valid_r || out_ch.ready) out_r <= res_nxt;
      else                              skid_r <= res_nxt;
    end else if (out_ch.ready && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.segments     = out_r.segments;
  assign out_ch.digit_enable = out_r.digit_enable;
  assign out_ch.drive_valid  = out_r.drive_valid;
  assign out_ch.accepted     = out_r.accepted;

endmodule

FILE: rtl/core/msd_checker.sv
// Port-level checks for the seven-segment driver, bound to the top level.
module msd_checker import msd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SEG_W-1:0] out_segments,
  input logic [DIG_W-1:0] out_digit_enable,
  input logic             out_drive_valid,
  input logic             out_accepted
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_segments)
      && $stable(out_digit_enable) && $stable(out_drive_valid) && $stable(out_accepted))
    else $error("result changed while stalled");

  a_drive_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_valid |-> $onehot(~out_digit_enable) && !out_accepted)
    else $error("refresh drive must enable one digit and not flag a write");

  a_write_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive_valid |-> out_segments == '0 && out_digit_enable == DIG_OFF)
    else $error("write result must leave display dark");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mux_seven_segment_driver msd_checker u_msd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_segments     (out_ch.segments),
  .out_digit_enable (out_ch.digit_enable),
  .out_drive_valid  (out_ch.drive_valid),
  .out_accepted     (out_ch.accepted)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the multiplexed seven-segment driver.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import msd_pkg::*;

  localparam int RAND_ITEMS = 1400;
  localparam int N_PHASES   = 8;
  localparam int LONG_HOLD  = 40;

  localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

  localparam logic [POS_W-1:0] POS_UNITS    = 2'd1;
  localparam logic [POS_W-1:0] POS_TENS     = 2'd2;
  localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd3;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [REQ_W-1:0]      req;
    logic [VALUE_W-1:0]    value;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  has_exp;
    result_t               exp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  msd_in_if  in_ch();
  msd_out_if out_ch();
  msd_cfg_if cfg_ch();

  mux_seven_segment_driver u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // display model state
  logic [POS_W-1:0]   disp_pos;
  logic [CODE_W-1:0]  disp_digit [1:3];
  logic [VALUE_W-1:0] finish_reg;
  logic [VALUE_W-1:0] dim_mode_reg;
  logic [DIM_W-1:0]   dim_cnt;
  logic [DIM_W-1:0]   period_lo;
  logic [DIM_W-1:0]   period_hi;
  logic [SEG_W-1:0]   glyph_rom [0:17];

  result_t  pending_results [$];
  dir_row_t dir_tab [$];

  int  errors = 0;
  int  n_items = 0;
  int  n_ticks = 0;
  int  n_refused = 0;
  int  n_dash = 0;
  int  n_cfg = 0;
  bit  src_idle_en = 1'b1;
  bit  snk_idle_en = 1'b1;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic dim_step(input logic [DIM_W-1:0] period);
    logic [DIM_W:0] nxt;
    nxt = {1'b0, dim_cnt} + 1'b1;
    if (nxt > {1'b0, period}) begin
      dim_cnt = '0;
      return 1'b1;
    end
    dim_cnt = nxt[DIM_W-1:0];
    return 1'b0;
  endfunction

  function automatic result_t next_display_result(input logic [REQ_W-1:0] req,
                                                  input logic [VALUE_W-1:0] val);
    result_t          res;
    logic [CODE_W-1:0] code;
    logic             lit;
    res = '{segments: '0, digit_enable: DIG_OFF, drive_valid: 1'b0, accepted: 1'b0};
    lit = 1'b1;
    case (req)
      REQ_TICK: begin
        disp_pos = (disp_pos == POS_HUNDREDS) ? POS_UNITS : disp_pos + 1'b1;
        code = disp_digit[disp_pos];
        if (code != CODE_BLANK) code = {1'b0, code[3:0]};
        if (dim_mode_reg == DIM_MODE_LOW) lit = dim_step(period_lo);
        else if (dim_mode_reg == DIM_MODE_HIGH) lit = dim_step(period_hi);
        else dim_cnt = '0;
        if (!lit) code = CODE_BLANK;
        if (finish_reg == FINISH_ON) code = CODE_DASH;
        res.segments     = glyph_rom[code];
        res.digit_enable = (disp_pos == POS_UNITS) ? DIG_UNITS :
                           (disp_pos == POS_TENS)  ? DIG_TENS  : DIG_HUNDREDS;
        res.drive_valid  = 1'b1;
      end
      REQ_UNITS, REQ_TENS, REQ_HUNDREDS: begin
        if (val <= DIGIT_MAX) begin
          disp_digit[req[1:0]] = val[CODE_W-1:0];
          res.accepted = 1'b1;
        end
      end
      REQ_FINISH: begin
        finish_reg   = val;
        res.accepted = 1'b1;
      end
      REQ_DIM: begin
        dim_mode_reg = val;
        res.accepted = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic result_t wr_res(input logic acc);
    return '{segments: '0, digit_enable: DIG_OFF, drive_valid: 1'b0, accepted: acc};
  endfunction

  function automatic result_t drv_res(input logic [SEG_W-1:0] seg, input logic [DIG_W-1:0] en);
    return '{segments: seg, digit_enable: en, drive_valid: 1'b1, accepted: 1'b0};
  endfunction

  function automatic void add_req(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
    dir_tab.push_back('{kind: ROW_REQ, req: req, value: val, cfg_idx: '0, cfg_data: '0,
                        has_exp: 1'b0, exp: '0});
  endfunction

  function automatic void add_chk(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                                  input result_t exp);
    dir_tab.push_back('{kind: ROW_REQ, req: req, value: val, cfg_idx: '0, cfg_data: '0,
                        has_exp: 1'b1, exp: exp});
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    dir_tab.push_back('{kind: ROW_CFG, req: REQ_TICK, value: '0, cfg_idx: idx, cfg_data: data,
                        has_exp: 1'b0, exp: '0});
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                              input logic typed, input result_t typed_res);
    result_t res;
    int      gap;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.value    <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = next_display_result(req, val);
    pending_results.push_back(typed ? typed_res : res);
    n_items++;
    if (req == REQ_TICK) n_ticks++;
    else if (!res.accepted) n_refused++;
    if (res.drive_valid && res.segments == glyph_rom[CODE_DASH]) n_dash++;
  endtask

  task automatic write_period(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_DIM_PERIOD_LOW) period_lo = data;
    else period_hi = data;
    n_cfg++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  function automatic logic [VALUE_W-1:0] rand_digit();
    if ($urandom_range(0, 4) == 0) return VALUE_W'($urandom_range(0, 255));
    return VALUE_W'($urandom_range(0, 9));
  endfunction

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got seg=%0h en=%0h dv=%0b acc=%0b",
                 $time, out_ch.segments, out_ch.digit_enable, out_ch.drive_valid,
                 out_ch.accepted);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("segments", int'(want.segments), int'(out_ch.segments));
        check_field("digit_enable", int'(want.digit_enable), int'(out_ch.digit_enable));
        check_field("drive_valid", int'(want.drive_valid), int'(out_ch.drive_valid));
        check_field("accepted", int'(want.accepted), int'(out_ch.accepted));
      end
    end
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [REQ_W-1:0]   req;
    logic [VALUE_W-1:0] val;
    logic [DIM_W-1:0]   lo;
    logic [DIM_W-1:0]   hi;
    int                 sent;
    int                 per_phase;
    int                 r;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.value    = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_DIM_PERIOD_LOW;
    cfg_ch.data    = '0;
    glyph_rom = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F,
                  7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h00, 7'h40};
    disp_pos     = '0;
    disp_digit   = '{CODE_BLANK, CODE_BLANK, CODE_BLANK};
    finish_reg   = '0;
    dim_mode_reg = '0;
    dim_cnt      = '0;
    period_lo    = DIM_PERIOD_LOW_RST;
    period_hi    = DIM_PERIOD_HIGH_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: blank after reset, digit range, undefined types, finish, dimming
    add_chk(REQ_TICK, 8'h00, drv_res(7'h00, DIG_UNITS));
    add_chk(REQ_UNITS, 8'd9, wr_res(1'b1));
    add_chk(REQ_UNITS, 8'd10, wr_res(1'b0));
    add_chk(REQ_UNITS, 8'hFF, wr_res(1'b0));
    add_chk(REQ_TENS, 8'd0, wr_res(1'b1));
    add_chk(REQ_HUNDREDS, 8'd9, wr_res(1'b1));
    add_chk(REQ_UNDEF_LO, 8'h00, wr_res(1'b0));
    add_chk(REQ_UNDEF_HI, 8'hFF, wr_res(1'b0));
    add_chk(REQ_TICK, 8'hFF, drv_res(7'h3F, DIG_TENS));
    add_chk(REQ_TICK, 8'h00, drv_res(7'h6F, DIG_HUNDREDS));
    add_chk(REQ_FINISH, FINISH_ON, wr_res(1'b1));
    add_chk(REQ_TICK, 8'h00, drv_res(7'h40, DIG_UNITS));
    add_chk(REQ_FINISH, 8'hFF, wr_res(1'b1));
    add_req(REQ_TICK, 8'h00);
    add_chk(REQ_DIM, DIM_MODE_LOW, wr_res(1'b1));
    repeat (4) add_req(REQ_TICK, 8'h5A);
    // period drops below a running dim count: next refresh lights
    add_cfg(CFG_DIM_PERIOD_HIGH, 4'hF);
    add_req(REQ_DIM, DIM_MODE_HIGH);
    repeat (5) add_req(REQ_TICK, 8'hA5);
    add_cfg(CFG_DIM_PERIOD_HIGH, 4'h1);
    repeat (2) add_req(REQ_TICK, 8'h00);

    foreach (dir_tab[j]) begin
      if (dir_tab[j].kind == ROW_CFG) begin
        drain_results();
        write_period(dir_tab[j].cfg_idx, dir_tab[j].cfg_data);
      end else begin
        send_request(dir_tab[j].req, dir_tab[j].value, dir_tab[j].has_exp, dir_tab[j].exp);
      end
    end
    drain_results();

    per_phase = RAND_ITEMS / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      src_idle_en = (ph < N_PHASES - 1);
      snk_idle_en = (ph < N_PHASES - 1);
      case (ph)
        0: begin lo = 4'h0; hi = 4'h0; end
        1: begin lo = 4'hF; hi = 4'hF; end
        2: begin lo = DIM_PERIOD_LOW_RST; hi = DIM_PERIOD_HIGH_RST; end
        3: begin lo = 4'h1; hi = 4'hF; end
        4: begin lo = 4'hF; hi = 4'h1; end
        default: begin
          lo = DIM_W'($urandom_range(0, 15));
          hi = DIM_W'($urandom_range(0, 15));
        end
      endcase
      write_period(CFG_DIM_PERIOD_LOW, lo);
      write_period(CFG_DIM_PERIOD_HIGH, hi);
      sent = 0;
      while (sent < per_phase) begin
        if (ph == 2 && sent >= 40 && !long_hold_done) begin
          long_hold_req  = 1'b1;
          long_hold_done = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          // noise: any type, any value
          repeat ($urandom_range(1, 5)) begin
            send_request(REQ_W'($urandom_range(0, 7)), VALUE_W'($urandom_range(0, 255)),
                         1'b0, '0);
            sent++;
          end
        end else begin
          // scene: a few writes, then a run of refreshes
          repeat ($urandom_range(0, 3)) begin
            req = REQ_W'($urandom_range(REQ_UNITS, REQ_HUNDREDS));
            send_request(req, rand_digit(), 1'b0, '0);
            sent++;
          end
          if ($urandom_range(0, 2) == 0) begin
            r = $urandom_range(0, 99);
            val = (r < 70) ? 8'h00 : (r < 88) ? FINISH_ON : 8'($urandom_range(0, 255));
            send_request(REQ_FINISH, val, 1'b0, '0);
            sent++;
          end
          if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(0, 3);
            val = (r == 0) ? 8'h00 : (r == 1) ? DIM_MODE_LOW :
                  (r == 2) ? DIM_MODE_HIGH : 8'($urandom_range(0, 255));
            send_request(REQ_DIM, val, 1'b0, '0);
            sent++;
          end
          repeat ($urandom_range(1, 40)) begin
            send_request(REQ_TICK, VALUE_W'($urandom_range(0, 255)), 1'b0, '0);
            sent++;
          end
        end
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Run: %0d requests, %0d refreshes, %0d refused writes, %0d dash refreshes,",
             n_items, n_ticks, n_refused, n_dash);
    $display("     %0d period writes over %0d settings, one long receiver hold-off.",
             n_cfg, N_PHASES + 2);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
